FILE: design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: word formats,
// controller commands, datapath status and character codes.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic        OP_PUT     = 1'b0;
  localparam logic        OP_READ    = 1'b1;
  localparam logic [7:0]  CH_NEWLINE = 8'd10;
  localparam logic [7:0]  CH_RETURN  = 8'd13;
  localparam logic [15:0] BLANK_CELL = 16'h0720;

  typedef struct packed {
    logic       opcode;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } tcw_in_t;

  typedef struct packed {
    logic [15:0] cell_entry;
    logic [4:0]  cursor_row_out;
    logic [6:0]  cursor_col_out;
  } tcw_out_t;

  typedef struct packed {
    logic clear_step;
    logic load_item;
    logic exec;
    logic blank_step;
    logic load_out;
  } tcw_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scroll;
    logic blank_last;
    logic out_free;
  } tcw_sts_t;

endpackage

FILE: design/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: design/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller: clearing pass, word intake, execution, scroll blanking and
// result hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  tcw_pkg::tcw_sts_t sts,
  output tcw_pkg::tcw_cmd_t cmd
);

  import tcw_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_BLANK,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.scroll ? S_BLANK : S_RESULT;
      end
      S_BLANK: begin
        cmd.blank_step = 1'b1;
        if (sts.blank_last) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      req_stall <= 1'b1;
    end else begin
      state     <= state_next;
      req_stall <= (state_next != S_IDLE);
    end
  end

endmodule

FILE: design/tcw_dp.sv
// ----------------------------------------------------------------------------
// tcw_dp
// Datapath: held word, cursor, circular top-row pointer, screen RAM address
// generation, sweep counters and result register.
// ----------------------------------------------------------------------------
module tcw_dp #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  tcw_pkg::tcw_cmd_t cmd,
  output tcw_pkg::tcw_sts_t sts,
  input  tcw_pkg::tcw_in_t  req,
  input  logic              rsp_stall,
  output logic              rsp_valid,
  output tcw_pkg::tcw_out_t rsp
);

  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);

  tcw_in_t       item;
  logic [RW-1:0] cursor_row;
  logic [CW-1:0] cursor_col;
  logic [RW-1:0] top;
  logic [RW-1:0] top_next;
  logic [RW-1:0] blank_row;
  logic [CW-1:0] blank_cnt;
  logic [AW-1:0] clear_cnt;

  logic          is_read;
  logic          is_nl;
  logic          is_cr;
  logic          is_char;
  logic [CW:0]   col_inc;
  logic          wrap;
  logic          row_adv;
  logic          last_row;
  logic          in_range;

  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_addr;
  logic [15:0]   ram_wdata;
  logic [15:0]   ram_rdata;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                              input logic [CW-1:0] col,
                                              input logic [RW-1:0] base);
    logic [RW:0]   sum;
    logic [RW-1:0] phys;
    sum = {1'b0, row} + {1'b0, base};
    if (sum >= (RW+1)'(ROWS)) begin
      sum = sum - (RW+1)'(ROWS);
    end
    phys = sum[RW-1:0];
    return AW'(phys) * AW'(COLUMNS) + AW'(col);
  endfunction

  assign is_read  = (item.opcode == OP_READ);
  assign is_nl    = !is_read && (item.char_code == CH_NEWLINE);
  assign is_cr    = !is_read && (item.char_code == CH_RETURN);
  assign is_char  = !is_read && !is_nl && !is_cr;
  assign col_inc  = {1'b0, cursor_col} + 1'b1;
  assign wrap     = (col_inc == (CW+1)'(COLUMNS));
  assign row_adv  = is_nl || (is_char && wrap);
  assign last_row = (cursor_row == RW'(ROWS - 1));
  assign top_next = (top == RW'(ROWS - 1)) ? '0 : top + 1'b1;
  assign in_range = (32'(item.read_row) < ROWS) && (32'(item.read_col) < COLUMNS);

  assign sts.clear_last = (clear_cnt == AW'(CELLS - 1));
  assign sts.scroll     = row_adv && last_row;
  assign sts.blank_last = (blank_cnt == CW'(COLUMNS - 1));
  assign sts.out_free   = !rsp_valid || !rsp_stall;

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = clear_cnt;
    ram_wdata = BLANK_CELL;
    if (cmd.clear_step) begin
      ram_we = 1'b1;
    end else if (cmd.blank_step) begin
      ram_we   = 1'b1;
      ram_addr = AW'(blank_row) * AW'(COLUMNS) + AW'(blank_cnt);
    end else if (cmd.exec) begin
      if (is_read) begin
        ram_re   = in_range;
        ram_addr = cell_addr(RW'(item.read_row), CW'(item.read_col), top);
      end else if (is_char) begin
        ram_we    = 1'b1;
        ram_addr  = cell_addr(cursor_row, cursor_col, top);
        ram_wdata = {item.attribute, item.char_code};
      end
    end
  end

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_screen (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_cnt  <= '0;
      cursor_row <= '0;
      cursor_col <= '0;
      top        <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clear_cnt <= clear_cnt + 1'b1;
      end
      if (cmd.exec && !is_read) begin
        if (is_cr) begin
          cursor_col <= '0;
        end else if (row_adv) begin
          cursor_col <= '0;
          if (last_row) begin
            top <= top_next;
          end else begin
            cursor_row <= cursor_row + 1'b1;
          end
        end else begin
          cursor_col <= col_inc[CW-1:0];
        end
      end
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= req;
    end
    // the row leaving at the top is reused as the new bottom row
    if (cmd.exec) begin
      blank_row <= top;
      blank_cnt <= '0;
    end else if (cmd.blank_step) begin
      blank_cnt <= blank_cnt + 1'b1;
    end
    if (cmd.load_out) begin
      rsp.cell_entry     <= (is_read && in_range) ? ram_rdata : 16'h0000;
      rsp.cursor_row_out <= 5'(cursor_row);
      rsp.cursor_col_out <= 7'(cursor_col);
    end
  end

endmodule

FILE: design/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text console of ROWS x COLUMNS 16-bit cells with a cursor: puts characters,
// handles newline, carriage return and scrolling, and reads cells back.
//
//   channel   direction  word       handshake
//   req       in         tcw_in_t   req_valid / req_stall
//   rsp       out        tcw_out_t  rsp_valid / rsp_stall
//
// A newline or wrap on the last row blanks the new bottom row one cell a
// cycle through the single screen RAM port (scroll moves a top-row pointer).
// After reset a clearing pass writes every cell with req_stall high. A
// stalled result holds in its register; the next word is accepted meanwhile
// and waits for the register to free before delivery.
// ----------------------------------------------------------------------------
module text_console_writer_core #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  tcw_pkg::tcw_in_t  req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output tcw_pkg::tcw_out_t rsp
);

  import tcw_pkg::*;

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcw_dp #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .req      (req),
    .rsp_stall(rsp_stall),
    .rsp_valid(rsp_valid),
    .rsp      (rsp)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("word accepted while busy");

  a_clear_blocks_input : assert property (@(posedge clk)
    rst |=> req_stall)
    else $error("input open during clearing pass");

  a_result_after_work : assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("result without a busy cycle");
`endif

endmodule

FILE: tb/text_console_writer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_writer_core_tb
// Self-checking bench for the text console writer. A fixed table of words
// covers reset contents, range limits, the control characters and a scroll;
// random bursts of text lines, reads and raw noise follow. Each result word
// is compared against the table's expected word or else against a shadow
// screen and cursor kept in the bench, with random gaps on req and stalls on rsp.
// ----------------------------------------------------------------------------
module text_console_writer_core_tb;
  import tcw_pkg::*;

  localparam int COLS       = COLUMNS_DEF;
  localparam int LINES      = ROWS_DEF;
  localparam int WORD_COUNT = 1400;

  typedef struct {
    tcw_in_t  word;
    bit       typed;
    tcw_out_t want;
    int       reps;
  } stim_row_t;

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_stall;
  tcw_in_t  req;
  logic     rsp_valid;
  logic     rsp_stall;
  tcw_out_t rsp;

  logic [15:0] shadow_cells [LINES*COLS];
  int unsigned cur_row;
  int unsigned cur_col;
  tcw_out_t    awaited_words [$];
  stim_row_t   plan [24];
  int unsigned fail_count;
  int unsigned words_sent;
  bit          steady;

  text_console_writer_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("text_console_writer_core_tb: FAIL");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic void line_feed();
    cur_col = 0;
    cur_row++;
    if (cur_row >= LINES) begin
      for (int i = 0; i + COLS < LINES*COLS; i++) shadow_cells[i] = shadow_cells[i + COLS];
      for (int i = (LINES - 1)*COLS; i < LINES*COLS; i++) shadow_cells[i] = BLANK_CELL;
      cur_row = LINES - 1;
    end
  endfunction

  function automatic tcw_out_t console_apply(tcw_in_t w);
    tcw_out_t res;
    res.cell_entry = '0;
    if (w.opcode == OP_READ) begin
      if (int'(w.read_row) < LINES && int'(w.read_col) < COLS)
        res.cell_entry = shadow_cells[int'(w.read_row)*COLS + int'(w.read_col)];
    end else if (w.char_code == CH_NEWLINE) begin
      line_feed();
    end else if (w.char_code == CH_RETURN) begin
      cur_col = 0;
    end else begin
      shadow_cells[cur_row*COLS + cur_col] = {w.attribute, w.char_code};
      cur_col++;
      if (cur_col >= COLS) line_feed();
    end
    res.cursor_row_out = cur_row[4:0];
    res.cursor_col_out = cur_col[6:0];
    return res;
  endfunction

  function automatic tcw_in_t mk_put(logic [7:0] ch, logic [7:0] attr);
    tcw_in_t w;
    w.opcode    = OP_PUT;
    w.char_code = ch;
    w.attribute = attr;
    w.read_row  = 5'h1F;
    w.read_col  = 7'h7F;
    return w;
  endfunction

  function automatic tcw_in_t mk_read(logic [4:0] row, logic [6:0] col);
    tcw_in_t w;
    w.opcode    = OP_READ;
    w.char_code = CH_NEWLINE;
    w.attribute = 8'hFF;
    w.read_row  = row;
    w.read_col  = col;
    return w;
  endfunction

  function automatic stim_row_t fixed_row(tcw_in_t w, logic [15:0] entry, int r, int c);
    stim_row_t s;
    s.word                = w;
    s.typed               = 1'b1;
    s.want.cell_entry     = entry;
    s.want.cursor_row_out = r[4:0];
    s.want.cursor_col_out = c[6:0];
    s.reps                = 1;
    return s;
  endfunction

  function automatic stim_row_t free_row(tcw_in_t w, int reps);
    stim_row_t s;
    s.word  = w;
    s.typed = 1'b0;
    s.want  = '0;
    s.reps  = reps;
    return s;
  endfunction

  task automatic send_word(tcw_in_t w, bit typed, tcw_out_t want);
    int       gap;
    tcw_out_t got;
    gap = steady ? 0 : idle_len();
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    do @(posedge clk); while (req_stall !== 1'b0);
    got = console_apply(w);
    awaited_words.push_back(typed ? want : got);
    words_sent++;
  endtask

  task automatic drain_all();
    req_valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(string field, int want, int got);
    fail_count++;
    $error("%s: expected %0h, got %0h", field, want, got);
  endtask

  // receiving side: random stall pattern
  initial begin
    int left;
    bit stall_q;
    left    = 0;
    stall_q = 1'b0;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (left > 0) begin
        left--;
      end else if (stall_q) begin
        stall_q = 1'b0;
        left    = $urandom_range(0, 10);
      end else begin
        left    = steady ? 0 : idle_len();
        stall_q = (left != 0);
        if (stall_q) left--;
      end
      rsp_stall <= stall_q;
    end
  end

  // result checker
  initial begin
    tcw_out_t want;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
        if (awaited_words.size() == 0) begin
          fail_count++;
          $error("unexpected result word %0h", rsp);
        end else begin
          want = awaited_words.pop_front();
          if (rsp.cell_entry !== want.cell_entry)
            note_mismatch("cell_entry", int'(want.cell_entry), int'(rsp.cell_entry));
          if (rsp.cursor_row_out !== want.cursor_row_out)
            note_mismatch("cursor_row_out", int'(want.cursor_row_out),
                          int'(rsp.cursor_row_out));
          if (rsp.cursor_col_out !== want.cursor_col_out)
            note_mismatch("cursor_col_out", int'(want.cursor_col_out),
                          int'(rsp.cursor_col_out));
        end
      end
    end
  end

  initial begin
    int          kind;
    int          len;
    int          n;
    int          c;
    int unsigned next_pause;
    logic [7:0]  attr_byte;
    logic [31:0] noise;
    tcw_in_t     w;

    fail_count = 0;
    words_sent = 0;
    steady     = 1'b0;
    next_pause = 350;
    for (int i = 0; i < LINES*COLS; i++) shadow_cells[i] = BLANK_CELL;
    cur_row = 0;
    cur_col = 0;

    plan[0]  = fixed_row(mk_read(5'd0, 7'd0), BLANK_CELL, 0, 0);
    plan[1]  = fixed_row(mk_read(5'd24, 7'd79), BLANK_CELL, 0, 0);
    plan[2]  = fixed_row(mk_read(5'd25, 7'd79), 16'h0000, 0, 0);
    plan[3]  = fixed_row(mk_read(5'd24, 7'd80), 16'h0000, 0, 0);
    plan[4]  = fixed_row(mk_read(5'd31, 7'd127), 16'h0000, 0, 0);
    plan[5]  = fixed_row(mk_put(8'h00, 8'h00), 16'h0000, 0, 1);
    plan[6]  = fixed_row(mk_put(8'hFF, 8'hFF), 16'h0000, 0, 2);
    plan[7]  = fixed_row(mk_read(5'd0, 7'd0), 16'h0000, 0, 2);
    plan[8]  = fixed_row(mk_read(5'd0, 7'd1), 16'hFFFF, 0, 2);
    plan[9]  = free_row(mk_put(8'd9, 8'h1F), 1);
    plan[10] = free_row(mk_put(8'd11, 8'h2E), 1);
    plan[11] = free_row(mk_put(8'd12, 8'h3C), 1);
    plan[12] = free_row(mk_put(8'd14, 8'h5A), 1);
    plan[13] = fixed_row(mk_put(CH_RETURN, 8'h11), 16'h0000, 0, 0);
    plan[14] = fixed_row(mk_put(8'h58, 8'h4A), 16'h0000, 0, 1);
    plan[15] = fixed_row(mk_read(5'd0, 7'd0), 16'h4A58, 0, 1);
    plan[16] = fixed_row(mk_put(CH_NEWLINE, 8'h00), 16'h0000, 1, 0);
    plan[17] = free_row(mk_put(CH_NEWLINE, 8'hFF), 23);
    plan[18] = free_row(mk_put(8'h5A, 8'h07), 1);
    plan[19] = free_row(mk_put(CH_NEWLINE, 8'h00), 1);
    plan[20] = free_row(mk_read(5'd23, 7'd0), 1);
    plan[21] = fixed_row(mk_read(5'd24, 7'd0), BLANK_CELL, 24, 0);
    plan[22] = free_row(mk_read(5'd0, 7'd0), 1);
    plan[23] = free_row(mk_put(CH_RETURN, 8'h00), 1);

    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[p])
      repeat (plan[p].reps) send_word(plan[p].word, plan[p].typed, plan[p].want);
    drain_all();

    while (words_sent < WORD_COUNT) begin
      kind   = $urandom_range(0, 99);
      steady = ($urandom_range(0, 99) < 12);
      if (kind < 50) begin
        // text line: mostly short, some long enough to wrap
        len       = ($urandom_range(0, 9) == 0) ? $urandom_range(81, 170)
                                                : $urandom_range(0, 60);
        attr_byte = 8'($urandom_range(0, 255));
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 29) == 0) begin
            send_word(mk_put(CH_RETURN, attr_byte), 1'b0, '0);
          end else begin
            do c = $urandom_range(0, 255); while (c == CH_NEWLINE || c == CH_RETURN);
            if ($urandom_range(0, 7) == 0) attr_byte = 8'($urandom_range(0, 255));
            send_word(mk_put(c[7:0], attr_byte), 1'b0, '0);
          end
        end
        if ($urandom_range(0, 9) < 7) send_word(mk_put(CH_NEWLINE, attr_byte), 1'b0, '0);
      end else if (kind < 80) begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          noise       = $urandom;
          w           = noise[$bits(tcw_in_t)-1:0];
          w.opcode    = OP_READ;
          w.read_row  = 5'($urandom_range(0, LINES - 1));
          w.read_col  = 7'($urandom_range(0, COLS - 1));
          if ($urandom_range(0, 99) < 15) begin
            if ($urandom_range(0, 1) == 1) begin
              w.read_row = 5'($urandom_range(LINES, 31));
              w.read_col = 7'($urandom_range(0, 127));
            end else begin
              w.read_col = 7'($urandom_range(COLS, 127));
              w.read_row = 5'($urandom_range(0, 31));
            end
          end else if ($urandom_range(0, 1) == 1) begin
            w.read_row = cur_row[4:0];
          end
          send_word(w, 1'b0, '0);
        end
      end else begin
        n = $urandom_range(1, 5);
        repeat (n) begin
          noise = $urandom;
          w     = noise[$bits(tcw_in_t)-1:0];
          send_word(w, 1'b0, '0);
        end
      end
      if (words_sent >= next_pause) begin
        steady = 1'b0;
        drain_all();
        next_pause += 350;
      end
    end

    steady = 1'b0;
    drain_all();
    repeat (4*COLS) @(posedge clk);
    if (fail_count == 0) begin
      $display("text_console_writer_core_tb: PASS");
    end else begin
      $display("text_console_writer_core_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/tcw_pkg.sv
design/tcw_ram.sv
design/tcw_ctrl.sv
design/tcw_dp.sv
design/text_console_writer_core.sv
tb/text_console_writer_core_tb.sv
